// ===== rtl/core/isfr_pkg.sv =====
package isfr_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd2;

	localparam logic [7:0] FIRST_ID_RST = 8'd85;
	localparam logic [7:0] SECOND_ID_RST = 8'd242;
	localparam logic [4:0] FRAME_LENGTH_RST = 5'd16;

	localparam logic [4:0] PHASE_WAIT = 5'd1;
	localparam logic [4:0] PHASE_FIRST = 5'd2;
	localparam logic [4:0] PHASE_TOP = 5'd30;
	localparam logic [4:0] MIN_LEN = 5'd4;

	typedef enum logic [9:0] {
		ST_RECV    = 10'b0000000001,
		ST_SUM_RD  = 10'b0000000010,
		ST_SUM_ACC = 10'b0000000100,
		ST_HI_RD   = 10'b0000001000,
		ST_HI_LD   = 10'b0000010000,
		ST_LO_RD   = 10'b0000100000,
		ST_CHECK   = 10'b0001000000,
		ST_EMIT_RD = 10'b0010000000,
		ST_EMIT_LD = 10'b0100000000,
		ST_SPARE   = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic recv;
		logic rd_en;
		logic acc;
		logic addr_trl;
		logic hi_ld;
		logic addr_first;
		logic addr_inc;
		logic out_err;
		logic out_data;
	} cmd_t;

	typedef struct packed {
		logic frame_done;
		logic sum_empty;
		logic at_end;
		logic good;
		logic slot_free;
	} stat_t;

endpackage

// ===== rtl/core/id_synced_frame_receiver_unit.sv =====
// Frame receiver: takes one byte per cycle while receiving, syncs on the ID pair,
// stores the frame in a MAX_FRAME-byte memory (contents undefined until written,
// no clearing pass) and, once the active frame length (frame_length clamped to
// 4..min(MAX_FRAME-1, 31)) is reached, holds off input requests for the checksum
// pass over the single memory read port: each summed byte (active length - 4) is
// read and then added, then the two trailer bytes are read and compared. A bad
// frame then gives one error request; a good one gives its payload bytes, each
// read and then loaded, held off while out_ready stalls. Bytes of the next frame
// are taken as soon as the last request of a run is loaded into the output register.
module id_synced_frame_receiver_unit import isfr_pkg::*; #(
	parameter int MAX_FRAME = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            payload_byte,
	output logic [4:0]            byte_index,
	output logic                  status,
	output logic                  last
);

	cmd_t  cmd;
	stat_t st;

	isfr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	isfr_datapath #(
		.MAX_FRAME (MAX_FRAME)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.rx_byte      (rx_byte),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.status       (status),
		.last         (last),
		.cmd          (cmd),
		.st           (st)
	);

	assign in_ready = cmd.recv;

endmodule

// ===== rtl/core/isfr_ctrl.sv =====
module isfr_ctrl import isfr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_RECV: begin
				cmd.recv = 1'b1;
				if (st.frame_done) state_d = ST_SUM_RD;
			end
			ST_SUM_RD: begin
				// length four: nothing to add beyond the ID pair
				if (st.sum_empty) begin
					cmd.addr_trl = 1'b1;
					state_d = ST_HI_RD;
				end else begin
					cmd.rd_en = 1'b1;
					state_d = ST_SUM_ACC;
				end
			end
			ST_SUM_ACC: begin
				cmd.acc = 1'b1;
				if (st.at_end) begin
					cmd.addr_trl = 1'b1;
					state_d = ST_HI_RD;
				end else begin
					state_d = ST_SUM_RD;
				end
			end
			ST_HI_RD: begin
				cmd.rd_en = 1'b1;
				state_d = ST_HI_LD;
			end
			ST_HI_LD: begin
				cmd.hi_ld = 1'b1;
				state_d = ST_LO_RD;
			end
			ST_LO_RD: begin
				cmd.rd_en = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!st.good) begin
					// hold until the output register is free
					if (st.slot_free) begin
						cmd.out_err = 1'b1;
						state_d = ST_RECV;
					end
				end else if (st.sum_empty) begin
					state_d = ST_RECV;
				end else begin
					cmd.addr_first = 1'b1;
					state_d = ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: begin
				cmd.rd_en = 1'b1;
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (st.slot_free) begin
					cmd.out_data = 1'b1;
					if (st.at_end) begin
						state_d = ST_RECV;
					end else begin
						cmd.addr_inc = 1'b1;
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_RECV;
			end
		endcase
	end

	a_done_starts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RECV && st.frame_done) |=> (state_q == ST_SUM_RD))
		else $error("frame completion did not start the checksum pass");

endmodule

// ===== rtl/core/isfr_datapath.sv =====
module isfr_datapath import isfr_pkg::*; #(
	parameter int MAX_FRAME = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                 in_valid,
	input  logic [7:0]           rx_byte,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [7:0]           payload_byte,
	output logic [4:0]           byte_index,
	output logic                 status,
	output logic                 last,
	input  cmd_t                 cmd,
	output stat_t                st
);

	localparam int AW = $clog2(MAX_FRAME);
	localparam logic [4:0] CAP = 5'((MAX_FRAME - 1 < 31) ? MAX_FRAME - 1 : 31);

	logic [7:0] first_id_q, second_id_q;
	logic [4:0] frame_length_q;
	logic [4:0] phase_q;
	logic [7:0] win0_q, win1_q, prev_q;
	logic [7:0] mem [MAX_FRAME];
	logic [7:0] rdata_q;
	logic [4:0] addr_q, len_q;
	logic [15:0] sum_q;
	logic [7:0] hi_q;
	logic out_valid_q;
	logic [7:0] payload_q;
	logic [4:0] index_q;
	logic status_q, last_q;

	logic in_fire, wr_en, frame_done;
	logic [4:0] len_act, phase_inc;
	logic [AW-1:0] wr_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_id_q <= FIRST_ID_RST;
			second_id_q <= SECOND_ID_RST;
			frame_length_q <= FRAME_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIRST_ID:     first_id_q <= cfg_data;
				REG_SECOND_ID:    second_id_q <= cfg_data;
				REG_FRAME_LENGTH: frame_length_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_length_q < MIN_LEN) len_act = MIN_LEN;
		else if (frame_length_q > CAP) len_act = CAP;
		else len_act = frame_length_q;
	end

	assign in_fire = in_valid && cmd.recv;
	assign phase_inc = phase_q + 5'd1;
	assign wr_addr = AW'(phase_q);
	assign wr_en = in_fire && (phase_q == PHASE_FIRST || (phase_q > PHASE_FIRST &&
		phase_q <= PHASE_TOP && int'(phase_q) < MAX_FRAME));
	assign frame_done = wr_en && phase_q != PHASE_FIRST &&
		!(prev_q == first_id_q && rx_byte == second_id_q) && phase_inc >= len_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_WAIT;
			win0_q <= 8'd0;
			win1_q <= 8'd0;
		end else if (in_fire) begin
			if (phase_q == PHASE_WAIT) begin
				win0_q <= win1_q;
				win1_q <= rx_byte;
				if (win1_q == first_id_q && rx_byte == second_id_q) phase_q <= PHASE_FIRST;
			end else if (phase_q == PHASE_FIRST) begin
				if (!(win1_q == first_id_q && rx_byte == second_id_q)) phase_q <= phase_inc;
			end else if (wr_en) begin
				// an ID pair inside the frame restarts it
				if (prev_q == first_id_q && rx_byte == second_id_q) phase_q <= PHASE_FIRST;
				else if (frame_done) phase_q <= PHASE_WAIT;
				else phase_q <= phase_inc;
			end else begin
				phase_q <= PHASE_WAIT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= rx_byte;
			prev_q <= rx_byte;
		end
		if (cmd.rd_en) rdata_q <= mem[AW'(addr_q)];
	end

	// ID bytes of the frame stay in the window, so the sum starts from them
	always_ff @(posedge clk) begin
		if (frame_done) begin
			len_q <= len_act;
			sum_q <= {8'd0, win0_q} + {8'd0, win1_q};
		end else if (cmd.acc) begin
			sum_q <= sum_q + {8'd0, rdata_q};
		end
		if (cmd.hi_ld) hi_q <= rdata_q;
		if (cmd.addr_trl) addr_q <= len_q - 5'd2;
		else if (cmd.addr_first || frame_done) addr_q <= PHASE_FIRST;
		else if (cmd.acc || cmd.hi_ld || cmd.addr_inc) addr_q <= addr_q + 5'd1;
	end

	assign st.frame_done = frame_done;
	assign st.sum_empty = (len_q == MIN_LEN);
	assign st.at_end = (addr_q == len_q - 5'd3);
	assign st.good = (sum_q == {hi_q, rdata_q});
	assign st.slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_data || cmd.out_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_err) begin
			payload_q <= 8'd0;
			index_q <= 5'd0;
			status_q <= 1'b1;
			last_q <= 1'b1;
		end else if (cmd.out_data) begin
			payload_q <= rdata_q;
			index_q <= addr_q - PHASE_FIRST;
			status_q <= 1'b0;
			last_q <= st.at_end;
		end
	end

	assign out_valid = out_valid_q;
	assign payload_byte = payload_q;
	assign byte_index = index_q;
	assign status = status_q;
	assign last = last_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_data || cmd.out_err) |-> (!out_valid_q || out_ready))
		else $error("output register loaded over a pending result");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> (phase_q == PHASE_WAIT))
		else $error("phase did not return to waiting after a complete frame");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q >= PHASE_WAIT) && (phase_q <= PHASE_TOP))
		else $error("phase left its range");

	a_emit_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_data |-> (addr_q >= PHASE_FIRST && addr_q <= len_q - 5'd3))
		else $error("payload read outside the frame payload");

endmodule
